>>> sv/can_frame_segment_batcher_macros.svh
// ----------------------------------------------------------------------------
// CAN frame segment batcher assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CAN_FRAME_SEGMENT_BATCHER_MACROS_SVH
`define CAN_FRAME_SEGMENT_BATCHER_MACROS_SVH

// same-cycle implication
`define CFSB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfsb assertion failed");

// next-cycle implication
`define CFSB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfsb assertion failed");

`endif

>>> sv/cfsb_pkg.sv
// ----------------------------------------------------------------------------
// cfsb_pkg
// Types, command codes and constants of the CAN frame segment batcher.
// ----------------------------------------------------------------------------
package cfsb_pkg;

    localparam int MAX_FRAMES_DEF = 16;

    localparam logic [31:0] FLUSH_DELAY_RST = 32'd10000;
    localparam logic [63:0] CS_SPAN_MAX     = 64'h0000_0000_0000_FFFF;
    localparam logic [63:0] MONO_SPAN_MAX   = 64'h0000_0000_FFFF_FFFF;

    localparam logic [2:0] CMD_PUSH    = 3'd0;
    localparam logic [2:0] CMD_TICK    = 3'd1;
    localparam logic [2:0] CMD_FLUSH   = 3'd2;
    localparam logic [2:0] CMD_DISCARD = 3'd3;
    localparam logic [2:0] CMD_EPOCH   = 3'd4;

    typedef struct packed {
        logic [63:0] cap_seq;
        logic [63:0] mono_us;
        logic [31:0] id_flags;
        logic [7:0]  len_flags;
        logic [7:0]  bus;
        logic [63:0] payload;
    } frame_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] now_us;
        frame_t      frame;
        logic [63:0] epoch_segment_seq;
    } item_t;

    typedef struct packed {
        logic [63:0] segment_number;
        logic [3:0]  entry_index;
        logic        entry_last;
        frame_t      frame;
    } result_t;

endpackage

>>> sv/cfsb_frame_mem.sv
// ----------------------------------------------------------------------------
// cfsb_frame_mem
// Pending frame store: one write port, one enabled read port, registered data.
// ----------------------------------------------------------------------------
module cfsb_frame_mem #(
    parameter int DEPTH = cfsb_pkg::MAX_FRAMES_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  cfsb_pkg::frame_t wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output cfsb_pkg::frame_t rd_data
);

    cfsb_pkg::frame_t mem [DEPTH];
    cfsb_pkg::frame_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/cfsb_seq.sv
// ----------------------------------------------------------------------------
// cfsb_seq
// Command sequencer: batch checks, frame store writes, segment readout and
// the result register.
// ----------------------------------------------------------------------------
module cfsb_seq #(
    parameter int MAX_FRAMES = cfsb_pkg::MAX_FRAMES_DEF,
    parameter int AW         = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [31:0]       flush_delay,
    input  logic              in_valid,
    output logic              in_ready,
    input  cfsb_pkg::item_t   item,
    output logic              out_valid,
    input  logic              out_ready,
    output cfsb_pkg::result_t result,
    output logic              mem_wr_en,
    output logic [AW-1:0]     mem_wr_addr,
    output cfsb_pkg::frame_t  mem_wr_data,
    output logic              mem_rd_en,
    output logic [AW-1:0]     mem_rd_addr,
    input  cfsb_pkg::frame_t  mem_rd_data
);

    localparam int CW = $clog2(MAX_FRAMES + 1);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_EXEC     = 5'b00010,
        ST_STORE    = 5'b00100,
        ST_DRAIN_RD = 5'b01000,
        ST_DRAIN_LD = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    cfsb_pkg::item_t   item_reg, item_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [31:0]       start_reg, start_next;
    logic [63:0]       seg_reg, seg_next;
    logic [63:0]       first_cs_reg, first_cs_next;
    logic [63:0]       first_mono_reg, first_mono_next;
    logic              after_store_reg, after_store_next;
    logic              out_valid_reg, out_valid_next;
    cfsb_pkg::result_t result_reg, result_next;

    logic [64:0]   cs_diff;
    logic [64:0]   mono_diff;
    logic [31:0]   age;
    logic          has_frames;
    logic          fits;
    logic          due;
    logic          out_free;
    logic          last_entry;
    logic [CW-1:0] idx_inc;
    logic [CW-1:0] count_inc;

    assign cs_diff    = {1'b0, item_reg.frame.cap_seq} - {1'b0, first_cs_reg};
    assign mono_diff  = {1'b0, item_reg.frame.mono_us} - {1'b0, first_mono_reg};
    assign age        = item_reg.now_us - start_reg;
    assign has_frames = (count_reg != '0);
    assign fits       = !has_frames ||
                        (!cs_diff[64] && (cs_diff[63:0] <= cfsb_pkg::CS_SPAN_MAX) &&
                         !mono_diff[64] && (mono_diff[63:0] <= cfsb_pkg::MONO_SPAN_MAX));
    assign due        = has_frames && (age >= flush_delay);
    assign out_free   = !out_valid_reg || out_ready;
    assign idx_inc    = idx_reg + 1'b1;
    assign count_inc  = count_reg + 1'b1;
    assign last_entry = (idx_inc == count_reg);

    always_comb
    begin
        state_next       = state_reg;
        item_next        = item_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        start_next       = start_reg;
        seg_next         = seg_reg;
        first_cs_next    = first_cs_reg;
        first_mono_next  = first_mono_reg;
        after_store_next = after_store_reg;
        result_next      = result_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = count_reg[AW-1:0];
        mem_wr_data      = item_reg.frame;
        mem_rd_en        = 1'b0;
        mem_rd_addr      = idx_reg[AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = item;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                idx_next         = '0;
                after_store_next = 1'b0;
                state_next       = ST_IDLE;
                unique case (item_reg.cmd)
                    cfsb_pkg::CMD_PUSH:
                    begin
                        // flush the pending batch first when the frame is out of span
                        if (!fits)
                        begin
                            after_store_next = 1'b1;
                            state_next       = ST_DRAIN_RD;
                        end
                        else
                        begin
                            state_next = ST_STORE;
                        end
                    end
                    cfsb_pkg::CMD_TICK:
                    begin
                        if (due)
                        begin
                            state_next = ST_DRAIN_RD;
                        end
                    end
                    cfsb_pkg::CMD_FLUSH:
                    begin
                        if (has_frames)
                        begin
                            state_next = ST_DRAIN_RD;
                        end
                    end
                    cfsb_pkg::CMD_DISCARD:
                    begin
                        count_next = '0;
                        start_next = '0;
                    end
                    cfsb_pkg::CMD_EPOCH:
                    begin
                        count_next = '0;
                        start_next = '0;
                        seg_next   = item_reg.epoch_segment_seq;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_STORE:
            begin
                mem_wr_en  = 1'b1;
                count_next = count_inc;
                if (!has_frames)
                begin
                    start_next      = item_reg.now_us;
                    first_cs_next   = item_reg.frame.cap_seq;
                    first_mono_next = item_reg.frame.mono_us;
                end
                if (count_inc == CW'(MAX_FRAMES))
                begin
                    idx_next         = '0;
                    after_store_next = 1'b0;
                    state_next       = ST_DRAIN_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DRAIN_RD:
            begin
                mem_rd_en  = 1'b1;
                state_next = ST_DRAIN_LD;
            end
            ST_DRAIN_LD:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    result_next.segment_number = seg_reg;
                    result_next.entry_index    = 4'(idx_reg);
                    result_next.entry_last     = last_entry;
                    result_next.frame          = mem_rd_data;
                    if (last_entry)
                    begin
                        count_next       = '0;
                        start_next       = '0;
                        seg_next         = seg_reg + 64'd1;
                        after_store_next = 1'b0;
                        state_next       = after_store_reg ? ST_STORE : ST_IDLE;
                    end
                    else
                    begin
                        // prefetch the next entry while this one is loaded
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = idx_inc[AW-1:0];
                        idx_next    = idx_inc;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            idx_reg         <= '0;
            start_reg       <= '0;
            seg_reg         <= '0;
            after_store_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            idx_reg         <= idx_next;
            start_reg       <= start_next;
            seg_reg         <= seg_next;
            after_store_reg <= after_store_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        first_cs_reg   <= first_cs_next;
        first_mono_reg <= first_mono_next;
        result_reg     <= result_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

>>> sv/can_frame_segment_batcher.sv
// Sequence: a push that stores without flushing passes the execute and store
// states. A flush adds a store read setup state, then reads out each pending
// frame (up to MAX_FRAMES), paced by the single read port of the frame store.
// One request is worked on at a time; results leave through a result register.
// Reset (rst_n, asynchronous): empty batch, segment 0, flush delay 10000 us.
// ----------------------------------------------------------------------------
// can_frame_segment_batcher
// Gathers captured CAN frames into numbered segments and emits them in order.
// ----------------------------------------------------------------------------
module can_frame_segment_batcher #(
    parameter int MAX_FRAMES = cfsb_pkg::MAX_FRAMES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic [31:0] now_us,
    input  logic [63:0] cap_seq,
    input  logic [63:0] mono_us,
    input  logic [31:0] id_flags,
    input  logic [7:0]  len_flags,
    input  logic [7:0]  bus_number,
    input  logic [63:0] payload_bytes,
    input  logic [63:0] epoch_segment_seq,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] segment_number,
    output logic [3:0]  entry_index,
    output logic        entry_last,
    output logic [63:0] out_cap_seq,
    output logic [63:0] out_mono_us,
    output logic [31:0] out_id_flags,
    output logic [7:0]  out_len_flags,
    output logic [7:0]  out_bus,
    output logic [63:0] out_payload
);

    localparam int AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    logic [31:0]       flush_delay_reg;
    cfsb_pkg::item_t   item;
    cfsb_pkg::result_t result;
    logic              mem_wr_en;
    logic [AW-1:0]     mem_wr_addr;
    cfsb_pkg::frame_t  mem_wr_data;
    logic              mem_rd_en;
    logic [AW-1:0]     mem_rd_addr;
    cfsb_pkg::frame_t  mem_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flush_delay_reg <= cfsb_pkg::FLUSH_DELAY_RST;
        end
        else if (cfg_we)
        begin
            flush_delay_reg <= cfg_wdata;
        end
    end

    assign item.cmd                   = cmd;
    assign item.now_us                = now_us;
    assign item.frame.cap_seq         = cap_seq;
    assign item.frame.mono_us         = mono_us;
    assign item.frame.id_flags        = id_flags;
    assign item.frame.len_flags       = len_flags;
    assign item.frame.bus             = bus_number;
    assign item.frame.payload         = payload_bytes;
    assign item.epoch_segment_seq     = epoch_segment_seq;

    cfsb_seq #(
        .MAX_FRAMES (MAX_FRAMES),
        .AW         (AW)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .flush_delay (flush_delay_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .item        (item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result      (result),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    cfsb_frame_mem #(
        .DEPTH (MAX_FRAMES),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign segment_number = result.segment_number;
    assign entry_index    = result.entry_index;
    assign entry_last     = result.entry_last;
    assign out_cap_seq    = result.frame.cap_seq;
    assign out_mono_us    = result.frame.mono_us;
    assign out_id_flags   = result.frame.id_flags;
    assign out_len_flags  = result.frame.len_flags;
    assign out_bus        = result.frame.bus;
    assign out_payload    = result.frame.payload;

endmodule

>>> sv/cfsb_checker.sv
// ----------------------------------------------------------------------------
// cfsb_checker
// Port-level checks of the CAN frame segment batcher, bound to the top level.
// ----------------------------------------------------------------------------
`include "can_frame_segment_batcher_macros.svh"

module cfsb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] segment_number,
    input logic [3:0]  entry_index,
    input logic        entry_last,
    input logic [63:0] out_cap_seq
);

    // stalled result holds
    `CFSB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_cap_seq))

    `CFSB_ASSERT_NEXT(a_index_hold, out_valid && !out_ready, $stable(entry_index))

    // no new request while a segment is still being read out
    `CFSB_ASSERT_NOW(a_busy_in_segment, out_valid && !entry_last, !in_ready)

    // an accepted request keeps the block busy for the next cycle
    `CFSB_ASSERT_NEXT(a_one_request, in_valid && in_ready, !in_ready)

    // all entries of one segment carry the same segment number
    `CFSB_ASSERT_NEXT(a_seg_steady, out_valid && out_ready && !entry_last, $stable(segment_number))

endmodule

bind can_frame_segment_batcher cfsb_checker u_cfsb_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .segment_number (segment_number),
    .entry_index    (entry_index),
    .entry_last     (entry_last),
    .out_cap_seq    (out_cap_seq)
);
